### sv/twin_prime_pair_checker_assert.svh
// Assertion macros shared by the twin prime pair checker RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef TWIN_PRIME_PAIR_CHECKER_ASSERT_SVH
`define TWIN_PRIME_PAIR_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tpp_pkg.sv
// Shared types and constants for the twin prime pair checker.
// No dependencies; imported by tpp_prime_unit and twin_prime_pair_checker.
package tpp_pkg;

    // Output tdata: one verdict bit padded to a byte.
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST_A,
        ST_TEST_B,
        ST_DONE
    } tpp_state_t;

    typedef enum logic [1:0] {
        PT_IDLE,
        PT_CHECK,
        PT_DIV,
        PT_TEST
    } tpp_prime_state_t;

    // Status from the primality unit to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic prime;
    } tpp_prime_status_t;

endpackage

### sv/tpp_prime_unit.sv
// Trial-division primality test, remainder formed one bit per cycle.
// Depends on tpp_pkg and twin_prime_pair_checker_assert.svh.
`include "twin_prime_pair_checker_assert.svh"

module tpp_prime_unit
    import tpp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    output tpp_prime_status_t      status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    tpp_prime_state_t         state_reg, state_next;
    logic                     done_reg, done_next;
    logic                     prime_reg, prime_next;
    logic [VALUE_WIDTH-1:0]   n_reg, n_next;
    logic [VALUE_WIDTH-1:0]   d_reg, d_next;
    logic [VALUE_WIDTH:0]     sq_reg, sq_next;      // d squared, tracked incrementally
    logic [VALUE_WIDTH-1:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0]   shift_reg, shift_next; // dividend bits, MSB first
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic [VALUE_WIDTH:0]     trial;
    logic [VALUE_WIDTH:0]     trial_sub;
    logic                     trial_ge;

    // one restoring-division step
    assign trial     = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign trial_sub = trial - {1'b0, d_reg};
    assign trial_ge  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            PT_IDLE:
            begin
                if (start)
                begin
                    n_next  = value;
                    d_next  = VALUE_WIDTH'(2);
                    sq_next = (VALUE_WIDTH+1)'(4);
                    if (value < VALUE_WIDTH'(2))
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        state_next = PT_CHECK;
                    end
                end
            end
            PT_CHECK:
            begin
                // d*d past n: no divisor left
                if (sq_reg > {1'b0, n_reg})
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = PT_IDLE;
                end
                else
                begin
                    rem_next   = '0;
                    shift_next = n_reg;
                    cnt_next   = CNT_W'(VALUE_WIDTH - 1);
                    state_next = PT_DIV;
                end
            end
            PT_DIV:
            begin
                rem_next   = trial_ge ? trial_sub[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
                shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    state_next = PT_TEST;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            PT_TEST:
            begin
                if (rem_reg == '0)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = PT_IDLE;
                end
                else
                begin
                    // (d+1)^2 = d^2 + 2d + 1
                    d_next     = d_reg + 1'b1;
                    sq_next    = sq_reg + {d_reg, 1'b1};
                    state_next = PT_CHECK;
                end
            end
            default:
            begin
                state_next = PT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
    end

    assign status.busy  = (state_reg != PT_IDLE);
    assign status.done  = done_reg;
    assign status.prime = prime_reg;

    `TPP_ASSERT_IMPLIES(a_rem_below_divisor, state_reg == PT_DIV, rem_reg < d_reg,
        "partial remainder not below divisor")
    `TPP_ASSERT_IMPLIES(a_prime_needs_two, done_reg && prime_reg, n_reg >= VALUE_WIDTH'(2),
        "value below two reported prime")
    `TPP_ASSERT_NEXT(a_start_leaves_idle, start && state_reg == PT_IDLE,
        done_reg || state_reg == PT_CHECK, "start neither finished nor began a check")

endmodule

### sv/twin_prime_pair_checker.sv
// Twin prime pair checker: top level, sequencer and output register.
// Depends on tpp_pkg, tpp_prime_unit and twin_prime_pair_checker_assert.svh.
//
//  channel   | direction | payload (lowest bit first)
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | first_value[W], second_value[W], zero pad to bytes
//  m_axis    | out       | is_twin_pair, zero pad to 8 bits
//
// Sequence: a pair whose difference is not two is not tested; it passes
// through ST_DONE to the output register. Otherwise tpp_prime_unit tests each
// value by trial division, with divisors from 2 while d*d <= n; each divisor
// passes through PT_CHECK, the bit-serial remainder loop PT_DIV and PT_TEST,
// and the second value is tested only when the first is prime.
// Reset: rst_n, asynchronous, clears the sequencer, prime unit and tvalid.
// Stalls: s_axis_tready is high only between transactions; a finished verdict
// parks in the output register so the next pair can enter while it waits.
`include "twin_prime_pair_checker_assert.svh"

module twin_prime_pair_checker
    import tpp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [W-1:0] first_value, [2W-1:W] second_value, rest zero
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] is_twin_pair, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    tpp_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;          // second value, held for test B
    logic                   verdict_reg, verdict_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   m_bit_reg, m_bit_next;

    logic [VALUE_WIDTH-1:0] first_value;
    logic [VALUE_WIDTH-1:0] second_value;
    logic [VALUE_WIDTH:0]   a_minus_b;
    logic [VALUE_WIDTH:0]   b_minus_a;
    logic                   diff_is_two;

    logic                   prime_start;
    logic [VALUE_WIDTH-1:0] prime_value;
    tpp_prime_status_t      prime_status;

    assign first_value  = s_axis_tdata[VALUE_WIDTH-1:0];
    assign second_value = s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];

    // exact difference: an extra top bit keeps a negative result from wrapping to 2
    assign a_minus_b   = {1'b0, first_value} - {1'b0, second_value};
    assign b_minus_a   = {1'b0, second_value} - {1'b0, first_value};
    assign diff_is_two = (a_minus_b == (VALUE_WIDTH+1)'(2))
                      || (b_minus_a == (VALUE_WIDTH+1)'(2));

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        b_next        = b_reg;
        verdict_next  = verdict_reg;
        m_bit_next    = m_bit_reg;
        m_tvalid_next = m_tvalid_reg && !m_axis_tready;
        prime_start   = 1'b0;
        prime_value   = first_value;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    b_next = second_value;
                    if (diff_is_two)
                    begin
                        prime_start = 1'b1;
                        state_next  = ST_TEST_A;
                    end
                    else
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_TEST_A:
            begin
                if (prime_status.done)
                begin
                    if (prime_status.prime)
                    begin
                        prime_start = 1'b1;
                        prime_value = b_reg;
                        state_next  = ST_TEST_B;
                    end
                    else
                    begin
                        verdict_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_TEST_B:
            begin
                if (prime_status.done)
                begin
                    verdict_next = prime_status.prime;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the output register once it is empty or being drained
                if (!m_tvalid_reg || m_axis_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_bit_next    = verdict_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg       <= b_next;
        verdict_reg <= verdict_next;
        m_bit_reg   <= m_bit_next;
    end

    tpp_prime_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_prime (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (prime_start),
        .value  (prime_value),
        .status (prime_status)
    );

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W-1)'(0), m_bit_reg};

    `TPP_ASSERT_IMPLIES(a_start_when_free, prime_start, !prime_status.busy,
        "prime unit started while busy")
    `TPP_ASSERT_IMPLIES(a_done_in_test, prime_status.done,
        state_reg == ST_TEST_A || state_reg == ST_TEST_B,
        "prime verdict arrived outside a test state")
    `TPP_ASSERT_IMPLIES(a_result_from_done, $rose(m_axis_tvalid), $past(state_reg) == ST_DONE,
        "output valid rose without a finished verdict")

endmodule
